[rtl/core/prime_sieve_engine_macros.svh]
// Assertion macros for the prime sieve engine.
// Included by files that check their own logic; no other dependencies.
`ifndef PRIME_SIEVE_ENGINE_MACROS_SVH
`define PRIME_SIEVE_ENGINE_MACROS_SVH

`ifndef SYNTHESIS

`define PSE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

`define PSE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define PSE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define PSE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/pse_pkg.sv]
// Shared constants and types of the prime sieve engine.
// No dependencies.
package pse_pkg;

  localparam int unsigned MAX_NUMBER = 4096;
  localparam int unsigned ADDR_W     = $clog2(MAX_NUMBER);
  localparam int unsigned CNT_W      = ADDR_W + 1;
  localparam int unsigned NUM_W      = 12;
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned STAT_W     = 2;

  localparam logic [NUM_W-1:0] LIMIT_RESET = NUM_W'(100);
  localparam logic [CNT_W-1:0] FIRST_PRIME = CNT_W'(2);
  localparam logic [CNT_W-1:0] TOP_NUMBER  = CNT_W'(MAX_NUMBER - 1);

  localparam logic [REQ_W-1:0] REQ_RUN   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd1;
  localparam logic [REQ_W-1:0] REQ_NEXT  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_RUN = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE   = 2'd2;

  typedef struct packed {
    logic              we;
    logic              wbit;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

[rtl/core/pse_req_if.sv]
// Request and response channels of the prime sieve engine.
// Depends on pse_pkg.
interface pse_req_if import pse_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [NUM_W-1:0] number;

  modport source (output valid, output req_type, output number, input ready);
  modport sink   (input valid, input req_type, input number, output ready);
endinterface

interface pse_rsp_if import pse_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              is_prime;
  logic [NUM_W-1:0]  value;
  logic              found;
  logic [STAT_W-1:0] status;

  modport source (output valid, output is_prime, output value, output found,
                  output status, input ready);
  modport sink   (input valid, input is_prime, input value, input found,
                  input status, output ready);
endinterface

[rtl/core/prime_sieve_engine.sv]
// Top level of the prime sieve engine: sequencer, shared adder and result register.
// Depends on pse_pkg, pse_req_if/pse_rsp_if, pse_mark_store and the macros header.
//
//   port          dir  width  what
//   req_i         in   2+12   request: req_type, number
//   rsp_o         out  1+12+1+2 result: is_prime, value, found, status
//   cfg_we_i/..   in   12     limit register write
//
// Run: writes marks 0..L for limit L, then scans them and clears the multiples of
// each prime; one shared 13-bit adder walks every pointer, one mark read or write
// per cycle. Query: one mark read. Next: reads marks upward until a prime or past L.
// No clearing pass after reset: a run rewrites marks 0..L before any read.
// A finished result waits in the output register; the next request is taken meanwhile.
`include "prime_sieve_engine_macros.svh"

module prime_sieve_engine import pse_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  pse_req_if.sink          req_i,
  pse_rsp_if.source        rsp_o,
  input  logic             cfg_we_i,
  input  logic [NUM_W-1:0] cfg_wdata_i
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_INIT     = 8'b0000_0010,
    S_SCAN_RD  = 8'b0000_0100,
    S_SCAN_CHK = 8'b0000_1000,
    S_CLEAR    = 8'b0001_0000,
    S_LOOK_RD  = 8'b0010_0000,
    S_LOOK_CHK = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [NUM_W-1:0]  limit_q;
  logic              sieved_q, sieved_d;
  logic [CNT_W-1:0]  ptr_q, ptr_d;
  logic [CNT_W-1:0]  mult_q, mult_d;
  logic [NUM_W-1:0]  count_q, count_d;
  logic              is_next_q, is_next_d;

  logic              res_prime_q, res_prime_d;
  logic [NUM_W-1:0]  res_value_q, res_value_d;
  logic              res_found_q, res_found_d;
  logic [STAT_W-1:0] res_stat_q, res_stat_d;

  logic              out_valid_q, out_valid_d;
  logic              out_prime_q;
  logic [NUM_W-1:0]  out_value_q;
  logic              out_found_q;
  logic [STAT_W-1:0] out_stat_q;
  logic              out_load;

  logic [CNT_W-1:0]  eff_lim;
  logic [CNT_W-1:0]  add_a, add_b, sum;
  logic              mark;
  mem_req_t          mem_req;

  assign eff_lim = ({1'b0, limit_q} > TOP_NUMBER) ? TOP_NUMBER : {1'b0, limit_q};

  always_comb begin
    add_a = ptr_q;
    add_b = CNT_W'(1);
    if (state_q == S_CLEAR && mult_q <= eff_lim) begin
      add_a = mult_q;
      add_b = ptr_q;
    end else if (state_q == S_SCAN_CHK && mark) begin
      add_b = ptr_q;
    end
  end

  assign sum = add_a + add_b;

  pse_mark_store u_store (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rd_bit_o  (mark)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || rsp_o.ready);

  always_comb begin
    state_d     = state_q;
    sieved_d    = sieved_q;
    ptr_d       = ptr_q;
    mult_d      = mult_q;
    count_d     = count_q;
    is_next_d   = is_next_q;
    res_prime_d = res_prime_q;
    res_value_d = res_value_q;
    res_found_d = res_found_q;
    res_stat_d  = res_stat_q;
    mem_req     = '{we: 1'b0, wbit: 1'b0,
                    waddr: ptr_q[ADDR_W-1:0], raddr: ptr_q[ADDR_W-1:0]};

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          res_prime_d = 1'b0;
          res_value_d = '0;
          res_found_d = 1'b0;
          res_stat_d  = STAT_OK;
          is_next_d   = (req_i.req_type == REQ_NEXT);
          priority if (req_i.req_type == REQ_RUN) begin
            ptr_d   = '0;
            count_d = '0;
            state_d = S_INIT;
          end else if (req_i.req_type == REQ_QUERY || req_i.req_type == REQ_NEXT) begin
            priority if (!sieved_q) begin
              res_stat_d = STAT_NOT_RUN;
              state_d    = S_DONE;
            end else if ({1'b0, req_i.number} > eff_lim) begin
              res_stat_d = STAT_RANGE;
              state_d    = S_DONE;
            end else begin
              ptr_d   = {1'b0, req_i.number};
              state_d = S_LOOK_RD;
            end
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_INIT: begin
        mem_req.we   = 1'b1;
        mem_req.wbit = (ptr_q >= FIRST_PRIME);
        ptr_d        = sum;
        if (sum > eff_lim) begin
          ptr_d   = FIRST_PRIME;
          state_d = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (ptr_q > eff_lim) begin
          res_value_d = count_q;
          sieved_d    = 1'b1;
          state_d     = S_DONE;
        end else begin
          state_d = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (mark) begin
          count_d = count_q + NUM_W'(1);
          mult_d  = sum;
          state_d = S_CLEAR;
        end else begin
          ptr_d   = sum;
          state_d = S_SCAN_RD;
        end
      end
      S_CLEAR: begin
        if (mult_q > eff_lim) begin
          ptr_d   = sum;
          state_d = S_SCAN_RD;
        end else begin
          mem_req.we    = 1'b1;
          mem_req.wbit  = 1'b0;
          mem_req.waddr = mult_q[ADDR_W-1:0];
          mult_d        = sum;
        end
      end
      S_LOOK_RD: begin
        state_d = S_LOOK_CHK;
      end
      S_LOOK_CHK: begin
        if (!is_next_q) begin
          res_prime_d = mark;
          state_d     = S_DONE;
        end else if (mark) begin
          res_value_d = ptr_q[NUM_W-1:0];
          res_found_d = 1'b1;
          state_d     = S_DONE;
        end else begin
          ptr_d   = sum;
          state_d = (sum > eff_lim) ? S_DONE : S_LOOK_RD;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      sieved_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      limit_q     <= LIMIT_RESET;
      sieved_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sieved_q    <= sieved_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q       <= ptr_d;
    mult_q      <= mult_d;
    count_q     <= count_d;
    is_next_q   <= is_next_d;
    res_prime_q <= res_prime_d;
    res_value_q <= res_value_d;
    res_found_q <= res_found_d;
    res_stat_q  <= res_stat_d;
    if (out_load) begin
      out_prime_q <= res_prime_q;
      out_value_q <= res_value_q;
      out_found_q <= res_found_q;
      out_stat_q  <= res_stat_q;
    end
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.is_prime = out_prime_q;
  assign rsp_o.value    = out_value_q;
  assign rsp_o.found    = out_found_q;
  assign rsp_o.status   = out_stat_q;

  `PSE_ASSERT_NXT(a_accept_leaves_idle, clk_i, rst_ni, req_i.valid && req_i.ready, state_q != S_IDLE)
  `PSE_ASSERT_IMP(a_check_after_read, clk_i, rst_ni, state_q == S_SCAN_CHK || state_q == S_LOOK_CHK, $past(state_q) == S_SCAN_RD || $past(state_q) == S_LOOK_RD)
  `PSE_ASSERT_IMP(a_found_is_clean, clk_i, rst_ni, rsp_o.valid && rsp_o.found, rsp_o.status == STAT_OK && !rsp_o.is_prime)

endmodule

[rtl/core/pse_mark_store.sv]
// One-bit-per-number mark memory with one write and one registered read port.
// Depends on pse_pkg.
module pse_mark_store import pse_pkg::*; (
  input  logic     clk_i,
  input  mem_req_t mem_req_i,
  output logic     rd_bit_o
);

  logic marks [MAX_NUMBER];
  logic rd_bit_q;

  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      marks[mem_req_i.waddr] <= mem_req_i.wbit;
    end
    rd_bit_q <= marks[mem_req_i.raddr];
  end

  assign rd_bit_o = rd_bit_q;

endmodule

[test/pse_sieve_checker.sv]
`timescale 1ns / 100ps
// Response checker for the prime sieve engine: watches the request, response and
// limit-write ports, predicts each answer and compares it. Depends on pse_pkg and
// the pse_req_if/pse_rsp_if interfaces.
module pse_sieve_checker import pse_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  pse_req_if               req_i,
  pse_rsp_if               rsp_i,
  input  logic             cfg_we_i,
  input  logic [NUM_W-1:0] cfg_wdata_i,
  output int unsigned      pending_o,
  output int unsigned      mismatches_o
);

  typedef struct packed {
    logic              is_prime;
    logic [NUM_W-1:0]  value;
    logic              found;
    logic [STAT_W-1:0] status;
  } sieve_answer_t;

  bit            sieve_marks [MAX_NUMBER];
  bit            sieve_done;
  int unsigned   sieve_limit;
  sieve_answer_t awaited_answers [$];
  int unsigned   mismatch_cnt;

  function automatic sieve_answer_t sieve_answer(input logic [REQ_W-1:0] kind,
                                                 input logic [NUM_W-1:0] num);
    sieve_answer_t ans;
    int unsigned   n;
    int unsigned   m;
    int unsigned   primes;
    ans    = '0;
    primes = 0;
    if (kind == REQ_RUN) begin
      for (n = 0; n < MAX_NUMBER; n++) begin
        sieve_marks[n] = (n >= FIRST_PRIME) && (n <= sieve_limit);
      end
      for (n = 32'(FIRST_PRIME); n <= sieve_limit; n++) begin
        if (sieve_marks[n]) begin
          primes++;
          for (m = 2 * n; m <= sieve_limit; m += n) sieve_marks[m] = 1'b0;
        end
      end
      sieve_done = 1'b1;
      ans.value  = NUM_W'(primes);
    end else if (kind == REQ_QUERY || kind == REQ_NEXT) begin
      if (!sieve_done) begin
        ans.status = STAT_NOT_RUN;
      end else if (num > sieve_limit) begin
        ans.status = STAT_RANGE;
      end else if (kind == REQ_QUERY) begin
        ans.is_prime = sieve_marks[num];
      end else begin
        for (n = 32'(num); n <= sieve_limit; n++) begin
          if (sieve_marks[n]) begin
            ans.value = NUM_W'(n);
            ans.found = 1'b1;
            break;
          end
        end
      end
    end
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sieve_answer_t want;
    sieve_answer_t got;
    if (!rst_ni) begin
      awaited_answers.delete();
      sieve_marks  = '{default: 1'b0};
      sieve_done   = 1'b0;
      sieve_limit  = 32'(LIMIT_RESET);
      mismatch_cnt = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        got = '{rsp_i.is_prime, rsp_i.value, rsp_i.found, rsp_i.status};
        if (awaited_answers.size() == 0) begin
          $display("%0t: response with none awaited: is_prime=%0d value=%0d found=%0d status=%0d",
                   $time, got.is_prime, got.value, got.found, got.status);
          mismatch_cnt++;
        end else begin
          want = awaited_answers.pop_front();
          if (got.is_prime !== want.is_prime) begin
            $display("%0t: is_prime expected %0d actual %0d", $time, want.is_prime, got.is_prime);
            mismatch_cnt++;
          end
          if (got.value !== want.value) begin
            $display("%0t: value expected %0d actual %0d", $time, want.value, got.value);
            mismatch_cnt++;
          end
          if (got.found !== want.found) begin
            $display("%0t: found expected %0d actual %0d", $time, want.found, got.found);
            mismatch_cnt++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            mismatch_cnt++;
          end
        end
      end
      if (cfg_we_i) begin
        sieve_limit = 32'(cfg_wdata_i);
        sieve_done  = 1'b0;
      end
      if (req_i.valid && req_i.ready) begin
        awaited_answers.push_back(sieve_answer(req_i.req_type, req_i.number));
      end
    end
    pending_o    <= awaited_answers.size();
    mismatches_o <= mismatch_cnt;
  end

endmodule

[test/prime_sieve_engine_tb.sv]
`timescale 1ns / 100ps
// Top of the prime sieve engine testbench: clock, reset, requests, limit writes,
// response back-pressure and the verdict. Depends on pse_pkg, the request and
// response interfaces, prime_sieve_engine and pse_sieve_checker.
module prime_sieve_engine_tb;
  import pse_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED    = 2'd3;
  localparam int unsigned      STALL_LIMIT   = 200000;
  localparam int unsigned      SEGMENTS      = 6;
  localparam int unsigned      SEGMENT_ITEMS = 12;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [NUM_W-1:0] cfg_wdata_i;
  int unsigned      send_idle_pct;
  int unsigned      recv_idle_pct;
  int unsigned      quiet_cycles;
  int unsigned      answers_pending;
  int unsigned      answer_mismatches;
  int unsigned      active_limit;

  pse_req_if req_if ();
  pse_rsp_if rsp_if ();

  prime_sieve_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  pse_sieve_checker answer_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .pending_o    (answers_pending),
    .mismatches_o (answer_mismatches)
  );

  always #1 clk_i = ~clk_i;

  task automatic send_request(input logic [REQ_W-1:0] kind, input logic [NUM_W-1:0] num);
    if ($urandom_range(99, 0) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99, 0) < send_idle_pct);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= kind;
    req_if.number   <= num;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic drain_answers();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (answers_pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [NUM_W-1:0] lim);
    drain_answers();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lim;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    active_limit = 32'(lim);
  endtask

  function automatic logic [NUM_W-1:0] pick_number();
    case ($urandom_range(7, 0))
      0: return NUM_W'($urandom_range(MAX_NUMBER - 1, 0));
      1: begin
        if (active_limit < MAX_NUMBER - 1) begin
          return NUM_W'($urandom_range(MAX_NUMBER - 1, active_limit + 1));
        end
        return NUM_W'($urandom);
      end
      default: return NUM_W'($urandom_range(active_limit, 0));
    endcase
  endfunction

  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_if.ready <= rst_ni && ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned roll;
    rst_ni          <= 1'b0;
    req_if.valid    <= 1'b0;
    req_if.req_type <= REQ_RUN;
    req_if.number   <= '0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= '0;
    active_limit    = 32'(LIMIT_RESET);
    send_idle_pct   = 36;
    recv_idle_pct   = 76;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(REQ_QUERY, 7);
    send_request(REQ_NEXT, 7);
    send_request(REQ_UNUSED, NUM_W'(MAX_NUMBER - 1));
    send_request(REQ_RUN, 0);
    send_request(REQ_QUERY, 0);
    send_request(REQ_QUERY, 1);
    send_request(REQ_QUERY, 2);
    send_request(REQ_QUERY, 97);
    send_request(REQ_QUERY, 100);
    send_request(REQ_QUERY, 101);
    send_request(REQ_NEXT, NUM_W'(MAX_NUMBER - 1));
    send_request(REQ_NEXT, 0);
    send_request(REQ_NEXT, 90);
    send_request(REQ_NEXT, 98);
    send_request(REQ_UNUSED, 0);
    send_request(REQ_QUERY, 97);

    write_limit(0);
    send_request(REQ_QUERY, 0);
    send_request(REQ_RUN, NUM_W'(MAX_NUMBER - 1));
    send_request(REQ_QUERY, 0);
    send_request(REQ_NEXT, 0);

    write_limit(1);
    send_request(REQ_RUN, 0);
    send_request(REQ_NEXT, 1);

    write_limit(NUM_W'(MAX_NUMBER - 1));
    send_request(REQ_RUN, 0);
    send_request(REQ_QUERY, 4093);
    send_request(REQ_NEXT, 4094);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == 2) begin
        send_idle_pct = 76;
        recv_idle_pct = 36;
      end else if (seg == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (seg)
        0:       write_limit(NUM_W'($urandom_range(60, 2)));
        1:       write_limit(2);
        3:       write_limit(NUM_W'($urandom_range(600, 100)));
        4:       write_limit(NUM_W'(MAX_NUMBER - 1));
        default: write_limit(NUM_W'($urandom));
      endcase
      if ($urandom_range(7, 0) != 0) send_request(REQ_RUN, NUM_W'($urandom));
      repeat (SEGMENT_ITEMS) begin
        roll = $urandom_range(99, 0);
        if (roll < 4) begin
          send_request(REQ_RUN, NUM_W'($urandom));
        end else if (roll < 8) begin
          send_request(REQ_UNUSED, NUM_W'($urandom));
        end else if (roll < 52) begin
          send_request(REQ_QUERY, pick_number());
        end else begin
          send_request(REQ_NEXT, pick_number());
        end
      end
    end

    drain_answers();
    repeat (20) @(posedge clk_i);
    if (answer_mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
